// ----- rtl/obbfa_pkg.sv -----
// Shared types and constants for the oriented-box face-axis overlap test.
// Used by the controller, the datapath and the top level; depends on nothing.
package obbfa_pkg;

	// Field widths
	localparam int POS_W  = 32;
	localparam int ROT_W  = 16;
	localparam int HALF_W = 31;

	// Fraction bits of the quaternion format; axis rounding and distance alignment
	localparam int ROT_FRAC_BITS = 14;

	// Internal widths
	localparam int MROW_W = 35;  // raw rotation matrix entry, Q(2*ROT_FRAC_BITS)
	localparam int AX_W   = 20;  // rounded axis component, Q(ROT_FRAC_BITS)
	localparam int QP_W   = 32;  // quaternion component product
	localparam int MUL_W  = 33;  // shared multiplier operand
	localparam int PROD_W = 66;  // shared multiplier product
	localparam int DOT_W  = 40;  // axis-axis dot product
	localparam int SPLIT  = 20;  // low slice of the dot magnitude per multiply
	localparam int HP_W   = 52;  // one half-size partial product
	localparam int DACC_W = 54;  // axis-distance dot product
	localparam int TOT_W  = 74;  // projected extent sum
	localparam int NPROD  = 10;  // quaternion products per box
	localparam int AX_N   = 18;  // six axes of three components
	localparam int AX_AW  = 5;

	// Quaternion product slots
	localparam logic [3:0] P_WW = 4'd0;
	localparam logic [3:0] P_XX = 4'd1;
	localparam logic [3:0] P_YY = 4'd2;
	localparam logic [3:0] P_ZZ = 4'd3;
	localparam logic [3:0] P_XY = 4'd4;
	localparam logic [3:0] P_XZ = 4'd5;
	localparam logic [3:0] P_YZ = 4'd6;
	localparam logic [3:0] P_WX = 4'd7;
	localparam logic [3:0] P_WY = 4'd8;
	localparam logic [3:0] P_WZ = 4'd9;

	// Quaternion component slots
	localparam logic [1:0] Q_W = 2'd0;
	localparam logic [1:0] Q_X = 2'd1;
	localparam logic [1:0] Q_Y = 2'd2;
	localparam logic [1:0] Q_Z = 2'd3;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_QMUL,
		OP_AXIS,
		OP_DOT,
		OP_HLO,
		OP_HHI,
		OP_DIST,
		OP_CMP
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_QMUL,
		ST_QWAIT,
		ST_AXIS,
		ST_PAIR,
		ST_DIST,
		ST_FINISH
	} state_t;

	typedef struct packed {
		op_t        op;
		logic       box;
		logic [3:0] k;
		logic [2:0] i;
		logic [2:0] j;
		logic [1:0] c;
		logic       first;
	} cmd_t;

	typedef struct packed {
		cmd_t cmd;
		logic load_a;
		logic load_b;
	} ctl_t;

	typedef struct packed {
		logic hit;
	} dp_stat_t;

endpackage

// ----- rtl/obbfa_in_if.sv -----
// Input channel for the box overlap test: valid/ready plus one box beat.
// Depends on obbfa_pkg for the field widths.
interface obbfa_in_if import obbfa_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic                     box_last;
	logic signed [POS_W-1:0]  pos_x;
	logic signed [POS_W-1:0]  pos_y;
	logic signed [POS_W-1:0]  pos_z;
	logic signed [ROT_W-1:0]  rot_w;
	logic signed [ROT_W-1:0]  rot_x;
	logic signed [ROT_W-1:0]  rot_y;
	logic signed [ROT_W-1:0]  rot_z;
	logic [HALF_W-1:0]        half_x;
	logic [HALF_W-1:0]        half_y;
	logic [HALF_W-1:0]        half_z;

	modport source (output valid, box_last, pos_x, pos_y, pos_z, rot_w, rot_x, rot_y, rot_z,
		half_x, half_y, half_z, input ready);
	modport sink (input valid, box_last, pos_x, pos_y, pos_z, rot_w, rot_x, rot_y, rot_z,
		half_x, half_y, half_z, output ready);
endinterface

// ----- rtl/obbfa_out_if.sv -----
// Result channel for the box overlap test: valid/ready plus the hit flag.
// Stands alone.
interface obbfa_out_if ();
	logic valid;
	logic ready;
	logic hit;

	modport source (output valid, hit, input ready);
	modport sink (input valid, hit, output ready);
endinterface

// ----- rtl/obbfa_dp.sv -----
// Datapath: held boxes, shared 33x33 multiplier pipeline, axis memory, accumulators.
// Depends on obbfa_pkg; driven by obbfa_ctrl through ctl_t.
module obbfa_dp import obbfa_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  ctl_t                    ctl,
	input  logic signed [POS_W-1:0] pos_x,
	input  logic signed [POS_W-1:0] pos_y,
	input  logic signed [POS_W-1:0] pos_z,
	input  logic signed [ROT_W-1:0] rot_w,
	input  logic signed [ROT_W-1:0] rot_x,
	input  logic signed [ROT_W-1:0] rot_y,
	input  logic signed [ROT_W-1:0] rot_z,
	input  logic [HALF_W-1:0]       half_x,
	input  logic [HALF_W-1:0]       half_y,
	input  logic [HALF_W-1:0]       half_z,
	output dp_stat_t                stat
);

	logic signed [POS_W-1:0]  pos_a_q  [3];
	logic signed [POS_W-1:0]  pos_b_q  [3];
	logic signed [ROT_W-1:0]  rot_a_q  [4];
	logic signed [ROT_W-1:0]  rot_b_q  [4];
	logic [HALF_W-1:0]        half_a_q [3];
	logic [HALF_W-1:0]        half_b_q [3];

	logic signed [QP_W-1:0]   prodf_q [NPROD];
	logic signed [AX_W-1:0]   axm     [AX_N];

	logic signed [DOT_W-1:0]  dot_q;
	logic signed [DACC_W-1:0] dacc_q;
	logic [TOT_W-1:0]         total_q;
	logic                     hit_q;

	cmd_t                     cmd;
	cmd_t                     cmd_s1;
	cmd_t                     cmd_s2;
	logic signed [MUL_W-1:0]  opa_s1;
	logic signed [MUL_W-1:0]  opb_s1;
	logic signed [AX_W-1:0]   rd_a_s1;
	logic signed [AX_W-1:0]   rd_b_s1;
	logic signed [PROD_W-1:0] prod_s2;

	logic [1:0]               qa_idx;
	logic [1:0]               qb_idx;
	logic signed [ROT_W-1:0]  qa_val;
	logic signed [ROT_W-1:0]  qb_val;
	logic signed [MUL_W-1:0]  dist_c;
	logic [DOT_W-1:0]         dot_mag;
	logic [HALF_W-1:0]        h_sel;
	logic signed [MUL_W-1:0]  opa0;
	logic signed [MUL_W-1:0]  opb0;
	logic [AX_AW-1:0]         ra;
	logic [AX_AW-1:0]         rb;
	logic [AX_AW-1:0]         wa;
	logic signed [MROW_W-1:0] mraw;
	logic signed [MROW_W-1:0] mrnd;
	logic signed [AX_W-1:0]   ax_new;
	logic signed [MUL_W-1:0]  mul_a;
	logic signed [MUL_W-1:0]  mul_b;
	logic [DACC_W-1:0]        dmag;
	logic [TOT_W-1:0]         reach;
	logic                     sep;

	assign cmd = ctl.cmd;

	// Capture box A on a beat with box_last low, box B on a last beat
	always_ff @(posedge clk) begin
		if (ctl.load_a) begin
			pos_a_q  <= '{pos_x, pos_y, pos_z};
			rot_a_q  <= '{rot_w, rot_x, rot_y, rot_z};
			half_a_q <= '{half_x, half_y, half_z};
		end
		if (ctl.load_b) begin
			pos_b_q  <= '{pos_x, pos_y, pos_z};
			rot_b_q  <= '{rot_w, rot_x, rot_y, rot_z};
			half_b_q <= '{half_x, half_y, half_z};
		end
	end

	// Pick the two quaternion components of product slot k
	always_comb begin
		unique case (cmd.k)
			P_WW:    begin qa_idx = Q_W; qb_idx = Q_W; end
			P_XX:    begin qa_idx = Q_X; qb_idx = Q_X; end
			P_YY:    begin qa_idx = Q_Y; qb_idx = Q_Y; end
			P_ZZ:    begin qa_idx = Q_Z; qb_idx = Q_Z; end
			P_XY:    begin qa_idx = Q_X; qb_idx = Q_Y; end
			P_XZ:    begin qa_idx = Q_X; qb_idx = Q_Z; end
			P_YZ:    begin qa_idx = Q_Y; qb_idx = Q_Z; end
			P_WX:    begin qa_idx = Q_W; qb_idx = Q_X; end
			P_WY:    begin qa_idx = Q_W; qb_idx = Q_Y; end
			P_WZ:    begin qa_idx = Q_W; qb_idx = Q_Z; end
			default: begin qa_idx = Q_W; qb_idx = Q_W; end
		endcase
		qa_val = cmd.box ? rot_b_q[qa_idx] : rot_a_q[qa_idx];
		qb_val = cmd.box ? rot_b_q[qb_idx] : rot_a_q[qb_idx];
	end

	// Center offset component, dot magnitude and half size of axis j
	always_comb begin
		dist_c  = MUL_W'(pos_b_q[cmd.c]) - MUL_W'(pos_a_q[cmd.c]);
		dot_mag = dot_q[DOT_W-1] ? DOT_W'(-dot_q) : DOT_W'(dot_q);
		if (cmd.j < 3'd3)
			h_sel = half_a_q[cmd.j[1:0]];
		else
			h_sel = half_b_q[2'(cmd.j - 3'd3)];
	end

	// Select the operands that do not come from the axis memory
	always_comb begin
		opa0 = '0;
		opb0 = '0;
		unique case (cmd.op)
			OP_QMUL: begin
				opa0 = MUL_W'(qa_val);
				opb0 = MUL_W'(qb_val);
			end
			OP_HLO: begin
				opa0 = MUL_W'(dot_mag[SPLIT-1:0]);
				opb0 = MUL_W'(h_sel);
			end
			OP_HHI: begin
				opa0 = MUL_W'(dot_mag[DOT_W-1:SPLIT]);
				opb0 = MUL_W'(h_sel);
			end
			OP_DIST: opb0 = dist_c;
			default: begin
				opa0 = '0;
				opb0 = '0;
			end
		endcase
	end

	// Form one rotation matrix entry from the stored products and round it
	always_comb begin
		unique case ({cmd.i[1:0], cmd.c})
			4'b0000: mraw = MROW_W'(prodf_q[P_WW]) + MROW_W'(prodf_q[P_XX])
				- MROW_W'(prodf_q[P_YY]) - MROW_W'(prodf_q[P_ZZ]);
			4'b0001: mraw = (MROW_W'(prodf_q[P_XY]) + MROW_W'(prodf_q[P_WZ])) <<< 1;
			4'b0010: mraw = (MROW_W'(prodf_q[P_XZ]) - MROW_W'(prodf_q[P_WY])) <<< 1;
			4'b0100: mraw = (MROW_W'(prodf_q[P_XY]) - MROW_W'(prodf_q[P_WZ])) <<< 1;
			4'b0101: mraw = MROW_W'(prodf_q[P_WW]) - MROW_W'(prodf_q[P_XX])
				+ MROW_W'(prodf_q[P_YY]) - MROW_W'(prodf_q[P_ZZ]);
			4'b0110: mraw = (MROW_W'(prodf_q[P_YZ]) + MROW_W'(prodf_q[P_WX])) <<< 1;
			4'b1000: mraw = (MROW_W'(prodf_q[P_XZ]) + MROW_W'(prodf_q[P_WY])) <<< 1;
			4'b1001: mraw = (MROW_W'(prodf_q[P_YZ]) - MROW_W'(prodf_q[P_WX])) <<< 1;
			4'b1010: mraw = MROW_W'(prodf_q[P_WW]) - MROW_W'(prodf_q[P_XX])
				- MROW_W'(prodf_q[P_YY]) + MROW_W'(prodf_q[P_ZZ]);
			default: mraw = '0;
		endcase
		mrnd   = (mraw + (MROW_W'(1) <<< (ROT_FRAC_BITS - 1))) >>> ROT_FRAC_BITS;
		ax_new = mrnd[AX_W-1:0];
	end

	// Axis memory addresses: component c of axis i, axis j, and write slot
	assign ra = AX_AW'({2'b00, cmd.i} * 5'd3 + {3'b000, cmd.c});
	assign rb = AX_AW'({2'b00, cmd.j} * 5'd3 + {3'b000, cmd.c});
	assign wa = AX_AW'((cmd.box ? 5'd9 : 5'd0) + {3'b000, cmd.i[1:0]} * 5'd3
		+ {3'b000, cmd.c});

	// Axis memory: one write port, two registered read ports
	always_ff @(posedge clk) begin
		if (cmd.op == OP_AXIS)
			axm[wa] <= ax_new;
		rd_a_s1 <= axm[ra];
		rd_b_s1 <= axm[rb];
	end

	// Stage 1 operands and stage 2 product
	always_comb begin
		mul_a = (cmd_s1.op == OP_DOT || cmd_s1.op == OP_DIST) ? MUL_W'(rd_a_s1) : opa_s1;
		mul_b = (cmd_s1.op == OP_DOT) ? MUL_W'(rd_b_s1) : opb_s1;
	end

	always_ff @(posedge clk) begin
		opa_s1  <= opa0;
		opb_s1  <= opb0;
		prod_s2 <= mul_a * mul_b;
	end

	// Command pipeline alongside the operands
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_s1 <= '{op: OP_NONE, default: '0};
			cmd_s2 <= '{op: OP_NONE, default: '0};
		end else begin
			cmd_s1 <= cmd;
			cmd_s2 <= cmd_s1;
		end
	end

	// Separation check on the current axis
	always_comb begin
		dmag  = dacc_q[DACC_W-1] ? DACC_W'(-dacc_q) : DACC_W'(dacc_q);
		reach = TOT_W'(dmag) << ROT_FRAC_BITS;
		sep   = total_q < reach;
	end

	// Store quaternion products, accumulate the rest; compare and clear at the end of each axis
	always_ff @(posedge clk) begin
		if (ctl.load_b) begin
			total_q <= '0;
			hit_q   <= 1'b1;
		end
		unique case (cmd_s2.op)
			OP_QMUL: prodf_q[cmd_s2.k] <= prod_s2[QP_W-1:0];
			OP_DOT:  dot_q <= cmd_s2.first ? prod_s2[DOT_W-1:0] : dot_q + prod_s2[DOT_W-1:0];
			OP_HLO:  total_q <= total_q + TOT_W'(prod_s2[HP_W-1:0]);
			OP_HHI:  total_q <= total_q + (TOT_W'(prod_s2[HP_W-1:0]) << SPLIT);
			OP_DIST: dacc_q <= cmd_s2.first ? prod_s2[DACC_W-1:0]
				: dacc_q + prod_s2[DACC_W-1:0];
			default: ;
		endcase
		if (cmd.op == OP_CMP) begin
			total_q <= '0;
			if (sep)
				hit_q <= 1'b0;
		end
	end

	assign stat.hit = hit_q;

endmodule

// ----- rtl/obbfa_ctrl.sv -----
// Controller: input handshake, micro-op sequencer and result register.
// Depends on obbfa_pkg; drives obbfa_dp through ctl_t.
module obbfa_ctrl import obbfa_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	input  logic     in_last,
	output logic     in_ready,
	output ctl_t     ctl,
	input  dp_stat_t stat,
	output logic     out_valid,
	output logic     out_hit,
	input  logic     out_ready
);

	state_t     state_q;
	state_t     state_d;
	logic       box_q;
	logic [3:0] k_q;
	logic [2:0] i_q;
	logic [2:0] j_q;
	logic [2:0] s_q;
	logic       out_valid_q;
	logic       res_q;
	logic       accept;
	logic       pub;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign pub      = (state_q == ST_FINISH) && (!out_valid_q || out_ready);

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (accept && in_last) state_d = ST_QMUL;
			ST_QMUL:   if (k_q == 4'd9) state_d = ST_QWAIT;
			ST_QWAIT:  if (s_q == 3'd1) state_d = ST_AXIS;
			ST_AXIS: begin
				if (s_q == 3'd2 && i_q == 3'd2)
					state_d = box_q ? ST_PAIR : ST_QMUL;
			end
			ST_PAIR:   if (s_q == 3'd6 && j_q == 3'd5) state_d = ST_DIST;
			ST_DIST: begin
				if (s_q == 3'd5)
					state_d = (i_q == 3'd5) ? ST_FINISH : ST_PAIR;
			end
			ST_FINISH: if (pub) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// Command outputs
	always_comb begin
		ctl.load_a    = accept && !in_last;
		ctl.load_b    = accept && in_last;
		ctl.cmd       = '{op: OP_NONE, default: '0};
		ctl.cmd.box   = box_q;
		ctl.cmd.k     = k_q;
		ctl.cmd.i     = i_q;
		ctl.cmd.j     = j_q;
		ctl.cmd.c     = s_q[1:0];
		ctl.cmd.first = (s_q == 3'd0);
		unique case (state_q)
			ST_QMUL: ctl.cmd.op = OP_QMUL;
			ST_AXIS: ctl.cmd.op = OP_AXIS;
			ST_PAIR: begin
				priority if (s_q <= 3'd2) ctl.cmd.op = OP_DOT;
				else if (s_q == 3'd5)     ctl.cmd.op = OP_HLO;
				else if (s_q == 3'd6)     ctl.cmd.op = OP_HHI;
				else                      ctl.cmd.op = OP_NONE;
			end
			ST_DIST: begin
				priority if (s_q <= 3'd2) ctl.cmd.op = OP_DIST;
				else if (s_q == 3'd5)     ctl.cmd.op = OP_CMP;
				else                      ctl.cmd.op = OP_NONE;
			end
			default: ctl.cmd.op = OP_NONE;
		endcase
	end

	// State, loop counters and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			box_q       <= 1'b0;
			k_q         <= '0;
			i_q         <= '0;
			j_q         <= '0;
			s_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				ST_IDLE: begin
					box_q <= 1'b0;
					k_q   <= '0;
					i_q   <= '0;
					j_q   <= '0;
					s_q   <= '0;
				end
				ST_QMUL: begin
					k_q <= k_q + 4'd1;
					s_q <= '0;
				end
				ST_QWAIT: begin
					s_q <= (s_q == 3'd1) ? 3'd0 : s_q + 3'd1;
					i_q <= '0;
				end
				ST_AXIS: begin
					if (s_q == 3'd2) begin
						s_q <= '0;
						if (i_q == 3'd2) begin
							i_q   <= '0;
							j_q   <= '0;
							k_q   <= '0;
							box_q <= 1'b1;
						end else begin
							i_q <= i_q + 3'd1;
						end
					end else begin
						s_q <= s_q + 3'd1;
					end
				end
				ST_PAIR: begin
					if (s_q == 3'd6) begin
						s_q <= '0;
						j_q <= (j_q == 3'd5) ? 3'd0 : j_q + 3'd1;
					end else begin
						s_q <= s_q + 3'd1;
					end
				end
				ST_DIST: begin
					if (s_q == 3'd5) begin
						s_q <= '0;
						i_q <= i_q + 3'd1;
					end else begin
						s_q <= s_q + 3'd1;
					end
				end
				default: ;
			endcase
			if (pub)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	// Hold the result for the output beat
	always_ff @(posedge clk) begin
		if (pub)
			res_q <= stat.hit;
	end

	assign out_valid = out_valid_q;
	assign out_hit   = res_q;

	a_pair_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_PAIR |-> (i_q <= 3'd5 && j_q <= 3'd5 && s_q <= 3'd6))
		else $error("pair counters out of range");

	a_axis_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_AXIS |-> (i_q <= 3'd2 && s_q <= 3'd2))
		else $error("axis entry counters out of range");

	a_publish: assert property (@(posedge clk) disable iff (!arst_n)
		pub |=> (out_valid_q && state_q == ST_IDLE))
		else $error("result not presented after publish");

endmodule

// ----- rtl/obb_overlap_face_axes.sv -----
// Top level of the oriented-box face-axis overlap test.
// Depends on obbfa_pkg, obbfa_in_if, obbfa_out_if, obbfa_ctrl and obbfa_dp.
//
//   channel   dir   payload                                   beat
//   box_in    in    box_last, pos_xyz, rot_wxyz, half_xyz     one box
//   hit_out   out   hit                                       one flag per box B
//
// A box A beat (box_last low) is stored as it is. A box B beat starts the run
// that makes the flag: every step goes through the one 33x33 multiplier
// (20 quaternion products, 108 axis dot terms, 72 half-size terms, 18 distance
// terms) plus pipeline bubbles. The result sits in an output register, so a new
// beat is taken while it waits. Reset clears the sequencer and the output valid;
// the held box is undefined until its first beat.
module obb_overlap_face_axes import obbfa_pkg::*; (
	input logic          clk,
	input logic          arst_n,
	obbfa_in_if.sink     box_in,
	obbfa_out_if.source  hit_out
);

	ctl_t     ctl;
	dp_stat_t stat;

	obbfa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (box_in.valid),
		.in_last   (box_in.box_last),
		.in_ready  (box_in.ready),
		.ctl       (ctl),
		.stat      (stat),
		.out_valid (hit_out.valid),
		.out_hit   (hit_out.hit),
		.out_ready (hit_out.ready)
	);

	obbfa_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.pos_x  (box_in.pos_x),
		.pos_y  (box_in.pos_y),
		.pos_z  (box_in.pos_z),
		.rot_w  (box_in.rot_w),
		.rot_x  (box_in.rot_x),
		.rot_y  (box_in.rot_y),
		.rot_z  (box_in.rot_z),
		.half_x (box_in.half_x),
		.half_y (box_in.half_y),
		.half_z (box_in.half_z),
		.stat   (stat)
	);

endmodule
